>>> rtl/rrh_pkg.sv
package rrh_pkg;

   localparam int WINDOW_DEPTH = 11;
   localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int WIN_IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

   localparam logic [31:0] RAD_K1 = 32'd3516961778;
   localparam logic [27:0] RAD_K2 = 28'd231000000;
   localparam logic [27:0] DIV_SCALE = 28'd200000000;

   localparam logic [13:0] CVD_B = 14'd10000;
   localparam logic [39:0] CVD_A = 40'(39083) << 24;
   localparam logic [15:0] TEMP_MUL = 16'd25600;
   localparam logic [57:0] TEMP_RND = 58'(1155) << 23;
   localparam logic [10:0] TEMP_DIV = 11'd1155;

   localparam logic signed [33:0] X_LOW = -34'sd59136000;
   localparam logic signed [33:0] X_HIGH = 34'sd251329155;
   localparam logic signed [18:0] TEMP_MIN = -19'sd51200;
   localparam logic signed [18:0] TEMP_MAX = 19'sd217600;

   localparam int DIV_STEPS = 54;
   localparam int ROOT_STEPS = 27;
   localparam int TDIV_STEPS = 19;

   localparam logic [2:0] REG_TARGET = 3'd0;
   localparam logic [2:0] REG_GAIN = 3'd1;
   localparam logic [2:0] REG_DMIN = 3'd2;
   localparam logic [2:0] REG_DMAX = 3'd3;
   localparam logic [2:0] REG_RUN = 3'd4;

endpackage

>>> rtl/rrh_req_if.sv
interface rrh_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] adc_code;
   modport source(output valid, output adc_code, input ready);
   modport sink(input valid, input adc_code, output ready);
endinterface

>>> rtl/rrh_rsp_if.sv
interface rrh_rsp_if;
   logic valid;
   logic ready;
   logic signed [18:0] temperature;
   logic signed [19:0] slope;
   logic [14:0] duty;
   logic window_full;
   modport source(output valid, output temperature, output slope, output duty,
                  output window_full, input ready);
   modport sink(input valid, input temperature, input slope, input duty,
                input window_full, output ready);
endinterface

>>> rtl/rtd_rate_of_rise_heater_control.sv
// a sample runs through multiply, bit-serial divide, 27-step root, temperature divide,
// window, slope, gain and clamp; the divide is skipped when the radicand is not
// positive and the temperature divide when the temperature saturates
// one transaction at a time, taken only in idle; a waiting result is held
// synchronous active-high reset clears control, registers to defaults, window empty
module rtd_rate_of_rise_heater_control (
   input  logic               clock,
   input  logic               reset,
   rrh_req_if.sink            req_chan,
   rrh_rsp_if.source          rsp_chan,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MUL    = 4'd1;
   localparam logic [3:0] S_PREP   = 4'd2;
   localparam logic [3:0] S_DIV    = 4'd3;
   localparam logic [3:0] S_SQRT   = 4'd4;
   localparam logic [3:0] S_TMUL   = 4'd5;
   localparam logic [3:0] S_TMUL2  = 4'd6;
   localparam logic [3:0] S_TCLAMP = 4'd7;
   localparam logic [3:0] S_TDIV   = 4'd8;
   localparam logic [3:0] S_TFIN   = 4'd9;
   localparam logic [3:0] S_WIN    = 4'd10;
   localparam logic [3:0] S_SLOPE  = 4'd11;
   localparam logic [3:0] S_GMUL   = 4'd12;
   localparam logic [3:0] S_ACC    = 4'd13;

   logic [3:0] state_ff, state_in;
   logic [5:0] cnt_ff, cnt_in;
   logic signed [15:0] code_ff, code_in;
   logic [48:0] prod_a_ff, prod_a_in;
   logic [43:0] prod_b_ff, prod_b_in;
   logic [43:0] dvsr_ff, dvsr_in;
   logic [43:0] rem_ff, rem_in;
   logic [53:0] dvd_ff, dvd_in;
   logic [53:0] dq_ff, dq_in;
   logic [27:0] rt_rem_ff, rt_rem_in;
   logic [26:0] root_ff, root_in;
   logic signed [41:0] tv_ff, tv_in;
   logic signed [33:0] x_ff, x_in;
   logic [10:0] trem_ff, trem_in;
   logic [18:0] ty_ff, ty_in;
   logic [18:0] tq_ff, tq_in;
   logic signed [18:0] temp_ff, temp_in;
   logic signed [18:0] win_ff [rrh_pkg::WINDOW_DEPTH];
   logic signed [18:0] win_in [rrh_pkg::WINDOW_DEPTH];
   logic [rrh_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic signed [19:0] slope_ff, slope_in;
   logic signed [20:0] diff_ff, diff_in;
   logic signed [31:0] gprod_ff, gprod_in;
   logic [14:0] acc_ff, acc_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic signed [18:0] rsp_temp_ff, rsp_temp_in;
   logic signed [19:0] rsp_slope_ff, rsp_slope_in;
   logic [14:0] rsp_duty_ff, rsp_duty_in;
   logic rsp_full_ff, rsp_full_in;

   logic signed [15:0] target_ff;
   logic [9:0] gain_ff;
   logic [14:0] dmin_ff, dmax_ff;
   logic run_ff;

   logic [15:0] u_val;
   logic [16:0] n_val;
   logic signed [49:0] num;
   logic [44:0] dtrial;
   logic [29:0] rtrial, rsub;
   logic [40:0] m_val;
   logic signed [57:0] p_val;
   logic signed [33:0] y_val;
   logic [11:0] ttrial;
   logic [rrh_pkg::WIN_IDX_W-1:0] old_idx;
   logic signed [33:0] acc_full;
   logic window_full;
   logic [44:0] dvsr_full;
   logic [19:0] temp_wide;
   logic cfg_write;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.temperature = rsp_temp_ff;
   assign rsp_chan.slope = rsp_slope_ff;
   assign rsp_chan.duty = rsp_duty_ff;
   assign rsp_chan.window_full = rsp_full_ff;

   assign csr_pready = 1'b1;
   assign cfg_write = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_paddr[4:2])
         rrh_pkg::REG_TARGET: csr_prdata = {16'd0, target_ff};
         rrh_pkg::REG_GAIN:   csr_prdata = {22'd0, gain_ff};
         rrh_pkg::REG_DMIN:   csr_prdata = {17'd0, dmin_ff};
         rrh_pkg::REG_DMAX:   csr_prdata = {17'd0, dmax_ff};
         rrh_pkg::REG_RUN:    csr_prdata = {31'd0, run_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= 16'sd43;
         gain_ff <= 10'd60;
         dmin_ff <= 15'd0;
         dmax_ff <= 15'd25600;
         run_ff <= 1'b0;
      end else if (cfg_write) begin
         case (csr_paddr[4:2])
            rrh_pkg::REG_TARGET: target_ff <= csr_pwdata[15:0];
            rrh_pkg::REG_GAIN:   gain_ff <= csr_pwdata[9:0];
            rrh_pkg::REG_DMIN:   dmin_ff <= csr_pwdata[14:0];
            rrh_pkg::REG_DMAX:   dmax_ff <= csr_pwdata[14:0];
            rrh_pkg::REG_RUN:    run_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      code_in = code_ff;
      prod_a_in = prod_a_ff;
      prod_b_in = prod_b_ff;
      dvsr_in = dvsr_ff;
      rem_in = rem_ff;
      dvd_in = dvd_ff;
      dq_in = dq_ff;
      rt_rem_in = rt_rem_ff;
      root_in = root_ff;
      tv_in = tv_ff;
      x_in = x_ff;
      trem_in = trem_ff;
      ty_in = ty_ff;
      tq_in = tq_ff;
      temp_in = temp_ff;
      win_in = win_ff;
      fill_in = fill_ff;
      slope_in = slope_ff;
      diff_in = diff_ff;
      gprod_in = gprod_ff;
      acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_temp_in = rsp_temp_ff;
      rsp_slope_in = rsp_slope_ff;
      rsp_duty_in = rsp_duty_ff;
      rsp_full_in = rsp_full_ff;

      // u = code + 32768, n = 65536 - u
      u_val = {~code_ff[15], code_ff[14:0]};
      n_val = 17'h10000 - {1'b0, u_val};
      num = $signed({1'b0, prod_a_ff}) - $signed({6'd0, prod_b_ff});
      dtrial = {rem_ff, dvd_ff[53]};
      rtrial = {rt_rem_ff, dq_ff[53:52]};
      rsub = {1'b0, root_ff, 2'b01};
      m_val = 41'(rrh_pkg::CVD_B * root_ff);
      p_val = 58'(tv_ff * $signed({1'b0, rrh_pkg::TEMP_MUL}))
              + $signed(rrh_pkg::TEMP_RND);
      y_val = x_ff - rrh_pkg::X_LOW;
      ttrial = {trem_ff, ty_ff[18]};
      old_idx = rrh_pkg::WIN_IDX_W'(fill_ff - 1'b1);
      acc_full = $signed({19'd0, acc_ff}) - 34'(gprod_ff);
      window_full = (fill_ff == rrh_pkg::FILL_W'(rrh_pkg::WINDOW_DEPTH));
      dvsr_full = 45'(rrh_pkg::DIV_SCALE * n_val);
      temp_wide = {1'b0, tq_ff} + 20'(rrh_pkg::TEMP_MIN);

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               code_in = req_chan.adc_code;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_a_in = 49'(rrh_pkg::RAD_K1 * n_val);
            prod_b_in = 44'(rrh_pkg::RAD_K2 * u_val);
            dvsr_in = dvsr_full[43:0];
            state_in = S_PREP;
         end
         S_PREP: begin
            dq_in = 54'd0;
            rt_rem_in = 28'd0;
            root_in = 27'd0;
            if (num > 50'sd0) begin
               rem_in = {2'b00, num[47:6]};
               dvd_in = {num[5:0], 48'd0};
               cnt_in = 6'(rrh_pkg::DIV_STEPS);
               state_in = S_DIV;
            end else begin
               cnt_in = 6'(rrh_pkg::ROOT_STEPS);
               state_in = S_SQRT;
            end
         end
         S_DIV: begin
            if (dtrial >= {1'b0, dvsr_ff}) begin
               rem_in = 44'(dtrial - {1'b0, dvsr_ff});
               dq_in = {dq_ff[52:0], 1'b1};
            end else begin
               rem_in = dtrial[43:0];
               dq_in = {dq_ff[52:0], 1'b0};
            end
            dvd_in = {dvd_ff[52:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               cnt_in = 6'(rrh_pkg::ROOT_STEPS);
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            // two radicand bits per step
            if (rtrial >= rsub) begin
               rt_rem_in = 28'(rtrial - rsub);
               root_in = {root_ff[25:0], 1'b1};
            end else begin
               rt_rem_in = rtrial[27:0];
               root_in = {root_ff[25:0], 1'b0};
            end
            dq_in = {dq_ff[51:0], 2'b00};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = S_TMUL;
         end
         S_TMUL: begin
            tv_in = $signed({2'b00, rrh_pkg::CVD_A}) - $signed({1'b0, m_val});
            state_in = S_TMUL2;
         end
         S_TMUL2: begin
            x_in = p_val[57:24];
            state_in = S_TCLAMP;
         end
         S_TCLAMP: begin
            tq_in = 19'd0;
            if (x_ff < rrh_pkg::X_LOW) begin
               temp_in = rrh_pkg::TEMP_MIN;
               state_in = S_WIN;
            end else if (x_ff >= rrh_pkg::X_HIGH) begin
               temp_in = rrh_pkg::TEMP_MAX;
               state_in = S_WIN;
            end else begin
               trem_in = {1'b0, y_val[28:19]};
               ty_in = y_val[18:0];
               cnt_in = 6'(rrh_pkg::TDIV_STEPS);
               state_in = S_TDIV;
            end
         end
         S_TDIV: begin
            if (ttrial >= {1'b0, rrh_pkg::TEMP_DIV}) begin
               trem_in = 11'(ttrial - {1'b0, rrh_pkg::TEMP_DIV});
               tq_in = {tq_ff[17:0], 1'b1};
            end else begin
               trem_in = ttrial[10:0];
               tq_in = {tq_ff[17:0], 1'b0};
            end
            ty_in = {ty_ff[17:0], 1'b0};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) state_in = S_TFIN;
         end
         S_TFIN: begin
            temp_in = temp_wide[18:0];
            state_in = S_WIN;
         end
         S_WIN: begin
            for (int i = rrh_pkg::WINDOW_DEPTH - 1; i > 0; i--) win_in[i] = win_ff[i-1];
            win_in[0] = temp_ff;
            if (!window_full) fill_in = fill_ff + 1'b1;
            state_in = S_SLOPE;
         end
         S_SLOPE: begin
            slope_in = 20'(win_ff[0]) - 20'(win_ff[old_idx]);
            diff_in = 21'(win_ff[0]) - 21'(win_ff[old_idx]) - 21'(target_ff);
            state_in = S_GMUL;
         end
         S_GMUL: begin
            gprod_in = 32'($signed({1'b0, gain_ff}) * diff_ff);
            state_in = S_ACC;
         end
         S_ACC: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               // upper clamp wins when the limits cross
               if (acc_full > $signed({19'd0, dmax_ff})) acc_in = dmax_ff;
               else if (acc_full < $signed({19'd0, dmin_ff})) acc_in = dmin_ff;
               else acc_in = acc_full[14:0];
               rsp_valid_in = 1'b1;
               rsp_temp_in = temp_ff;
               rsp_slope_in = slope_ff;
               rsp_full_in = window_full;
               rsp_duty_in = (window_full && run_ff) ? acc_in : 15'd0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= 6'd0;
         fill_ff <= '0;
         acc_ff <= 15'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < rrh_pkg::WINDOW_DEPTH; i++) win_ff[i] <= 19'sd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         fill_ff <= fill_in;
         acc_ff <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff <= win_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      prod_a_ff <= prod_a_in;
      prod_b_ff <= prod_b_in;
      dvsr_ff <= dvsr_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dq_ff <= dq_in;
      rt_rem_ff <= rt_rem_in;
      root_ff <= root_in;
      tv_ff <= tv_in;
      x_ff <= x_in;
      trem_ff <= trem_in;
      ty_ff <= ty_in;
      tq_ff <= tq_in;
      temp_ff <= temp_in;
      slope_ff <= slope_in;
      diff_ff <= diff_in;
      gprod_ff <= gprod_in;
      rsp_temp_ff <= rsp_temp_in;
      rsp_slope_ff <= rsp_slope_in;
      rsp_duty_ff <= rsp_duty_in;
      rsp_full_ff <= rsp_full_in;
   end

endmodule

>>> tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REG_SPARE = 3'd5;
   localparam int DRAIN_CYCLES = 150;
   localparam int STALL_LIMIT = 3000;

   typedef struct {
      logic signed [18:0] temperature;
      logic signed [19:0] slope;
      logic [14:0]        duty;
      logic               window_full;
   } rise_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   rrh_req_if req_chan ();
   rrh_rsp_if rsp_chan ();

   rtd_rate_of_rise_heater_control dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // controller copy
   logic signed [15:0] ctl_target;
   logic [9:0] ctl_gain;
   logic [14:0] ctl_dmin;
   logic [14:0] ctl_dmax;
   logic ctl_run;
   int temp_history [rrh_pkg::WINDOW_DEPTH];
   int samples_held;
   int heater_acc;

   rise_result_type pending_readings [$];
   int error_count = 0;
   bit idling_on = 1'b1;
   int quiet_cycles = 0;
   int ramp_code = 0;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic int bridge_temperature(logic signed [15:0] code);
      longint u, n, num, t, p, dd;
      longint unsigned d, q, rem, s;
      u = longint'(code) + 32768;
      n = 65536 - u;
      num = 64'sd3516961778 * n - 64'sd231000000 * u;
      q = 0;
      // radicand as Q.48, zero when not positive
      if (num > 0) begin
         d = 2 * longint'(n) * 64'd100000000;
         q = longint'(num) / d;
         rem = longint'(num) % d;
         for (int k = 0; k < 3; k++) begin
            rem = rem << 16;
            q = (q << 16) | (rem / d);
            rem = rem % d;
         end
      end
      s = int_sqrt(q);
      dd = 64'sd1155 << 24;
      p = (64'sd39083 * (64'sd1 << 24) - 64'sd10000 * longint'(s)) * 25600
          + (64'sd1155 << 23);
      if (p >= 0) t = p / dd;
      else t = -((-p + dd - 1) / dd);
      if (t < -51200) t = -51200;
      if (t > 217600) t = 217600;
      return int'(t);
   endfunction

   function automatic rise_result_type predict_reading(logic signed [15:0] code);
      rise_result_type r;
      int temp;
      longint slope_v, acc;
      bit full;
      temp = bridge_temperature(code);
      for (int i = rrh_pkg::WINDOW_DEPTH - 1; i > 0; i--)
         temp_history[i] = temp_history[i - 1];
      temp_history[0] = temp;
      if (samples_held < rrh_pkg::WINDOW_DEPTH) samples_held++;
      full = (samples_held == rrh_pkg::WINDOW_DEPTH);
      slope_v = longint'(temp_history[0]) - longint'(temp_history[samples_held - 1]);
      acc = longint'(heater_acc) - longint'(ctl_gain) * (slope_v - longint'(ctl_target));
      // upper clamp wins over lower when limits cross
      if (acc > longint'(ctl_dmax)) acc = longint'(ctl_dmax);
      else if (acc < longint'(ctl_dmin)) acc = longint'(ctl_dmin);
      heater_acc = int'(acc);
      r.temperature = temp[18:0];
      r.slope = slope_v[19:0];
      r.duty = (full && ctl_run) ? acc[14:0] : 15'd0;
      r.window_full = full;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      error_count++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
   endtask

   task automatic csr_write(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         rrh_pkg::REG_TARGET: ctl_target = value[15:0];
         rrh_pkg::REG_GAIN: ctl_gain = value[9:0];
         rrh_pkg::REG_DMIN: ctl_dmin = value[14:0];
         rrh_pkg::REG_DMAX: ctl_dmax = value[14:0];
         rrh_pkg::REG_RUN: ctl_run = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // always entered and left at a falling edge
   task automatic send_sample(logic signed [15:0] code);
      if (idling_on && $urandom_range(0, 7) == 0) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.adc_code = code;
      do @(posedge clock); while (!req_chan.ready);
      pending_readings.push_back(predict_reading(code));
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_chan.valid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] next_code();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 2) return 16'($urandom());
      if (pick < 3) ramp_code = $urandom_range(0, 20500) - 7500;
      else ramp_code = ramp_code + $urandom_range(0, 80) - 30;
      if (ramp_code > 13000) ramp_code = -7500;
      if (ramp_code < -8000) ramp_code = -8000;
      return 16'(ramp_code);
   endfunction

   task automatic test_code_extremes();
      logic signed [15:0] codes [$];
      codes = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001, -16'sd7600,
                -16'sd7400, 16'sd12700, 16'sd12900, 16'sd30000, 16'sd32000,
                -16'sd20000, 16'sh5555, 16'shAAAA, 16'sd4000};
      foreach (codes[i]) send_sample(codes[i]);
      wait_idle();
   endtask

   task automatic test_register_limits();
      csr_write(rrh_pkg::REG_RUN, 32'd1);
      csr_write(rrh_pkg::REG_TARGET, 32'h0000_8000);
      csr_write(rrh_pkg::REG_GAIN, 32'd1023);
      repeat (30) send_sample(next_code());
      wait_idle();
      csr_write(rrh_pkg::REG_TARGET, 32'h0000_7FFF);
      csr_write(rrh_pkg::REG_GAIN, 32'd0);
      repeat (20) send_sample(next_code());
      wait_idle();
      // crossed limits, then masked out-of-range values, then a spare address
      csr_write(rrh_pkg::REG_GAIN, 32'd1023);
      csr_write(rrh_pkg::REG_DMIN, 32'd25600);
      csr_write(rrh_pkg::REG_DMAX, 32'd100);
      repeat (30) send_sample(next_code());
      wait_idle();
      csr_write(rrh_pkg::REG_DMIN, 32'hFFFF_FFFF);
      csr_write(rrh_pkg::REG_DMAX, 32'hFFFF_FFFF);
      csr_write(rrh_pkg::REG_TARGET, 32'hFFFF_FFFF);
      csr_write(rrh_pkg::REG_GAIN, 32'hFFFF_FFFF);
      csr_write(rrh_pkg::REG_RUN, 32'hFFFF_FFFE);
      csr_write(REG_SPARE, 32'h1234_5678);
      repeat (30) send_sample(next_code());
      wait_idle();
   endtask

   task automatic test_random_control();
      for (int phase = 0; phase < 15; phase++) begin
         if (phase == 13) idling_on = 1'b0;
         csr_write(rrh_pkg::REG_TARGET,
                   $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 600));
         csr_write(rrh_pkg::REG_GAIN,
                   $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 100));
         csr_write(rrh_pkg::REG_DMIN,
                   $urandom_range(0, 4) == 0 ? $urandom_range(0, 25600) : 0);
         csr_write(rrh_pkg::REG_DMAX,
                   $urandom_range(0, 4) == 0 ? $urandom_range(0, 25600) : 25600);
         csr_write(rrh_pkg::REG_RUN, {31'd0, $urandom_range(0, 3) != 0});
         repeat (100) send_sample(next_code());
         wait_idle();
      end
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.adc_code = '0;
      rsp_chan.ready = 1'b0;
      ctl_target = 16'sd43;
      ctl_gain = 10'd60;
      ctl_dmin = 15'd0;
      ctl_dmax = 15'd25600;
      ctl_run = 1'b0;
      foreach (temp_history[i]) temp_history[i] = 0;
      samples_held = 0;
      heater_acc = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_code_extremes();
      test_register_limits();
      test_random_control();
      if (error_count == 0) $display("rtd_rate_of_rise_heater_control regression: pass");
      else $display("rtd_rate_of_rise_heater_control regression: fail");
      $finish;
   end

   initial begin
      @(negedge clock);
      while (1) begin
         if (idling_on && $urandom_range(0, 3) == 0) rsp_chan.ready = 1'b0;
         else rsp_chan.ready = 1'b1;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      rise_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_readings.size() == 0) begin
            report_mismatch("unexpected transaction temperature", rsp_chan.temperature, 0);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_chan.temperature !== want.temperature)
               report_mismatch("temperature", rsp_chan.temperature, want.temperature);
            if (rsp_chan.slope !== want.slope)
               report_mismatch("slope", rsp_chan.slope, want.slope);
            if (rsp_chan.duty !== want.duty)
               report_mismatch("duty", rsp_chan.duty, want.duty);
            if (rsp_chan.window_full !== want.window_full)
               report_mismatch("window_full", rsp_chan.window_full, want.window_full);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_psel && csr_penable) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("rtd_rate_of_rise_heater_control regression: fail");
         $finish;
      end
   end

endmodule

>>> sim.f
rtl/rrh_pkg.sv
rtl/rrh_req_if.sv
rtl/rrh_rsp_if.sv
rtl/rtd_rate_of_rise_heater_control.sv
tb/sv/tb.sv
